// ===== hdl/qot_pkg.sv =====
// qot_pkg: shared types and constants for the quaternion orientation tracker
// used by qot_div and quaternion_orientation_tracker_top
package qot_pkg;
	localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
	localparam logic signed [15:0] ONE_Q8 = 16'sd256;

	localparam logic OP_ROTATE = 1'b0;
	localparam logic OP_ZOOM = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_HAM,
		ST_SQ,
		ST_SQRT,
		ST_DIVS,
		ST_DIVW,
		ST_MAT,
		ST_OFS,
		ST_OUT
	} state_t;

	function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
		if (v > 48'sd32767) return 16'sh7fff;
		if (v < -48'sd32768) return 16'sh8000;
		return v[15:0];
	endfunction
endpackage

// ===== hdl/qot_div.sv =====
// qot_div: restoring divider, one quotient bit per cycle, 40 bit by 32 bit
// depends on qot_pkg
module qot_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [39:0] num,
	input  logic [31:0] den,
	output logic busy,
	output logic [39:0] quo
);
	import qot_pkg::*;

	logic [32:0] rem_q;
	logic [39:0] quo_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic [32:0] trial;

	assign trial = {rem_q[31:0], quo_q[39]};
	assign busy = busy_q;
	assign quo = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 6'd39;
		end else if (busy_q) begin
			if (cnt_q == 6'd0) busy_q <= 1'b0;
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			if (trial >= {1'b0, den}) begin
				rem_q <= trial - {1'b0, den};
				quo_q <= {quo_q[38:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[38:0], 1'b0};
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) start |=> busy_q);
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && cnt_q == 6'd0 |=> !busy_q);
	assert property (@(posedge clk) disable iff (!arst_n) busy_q |-> cnt_q <= 6'd39);
endmodule

// ===== hdl/quaternion_orientation_tracker_top.sv =====
// quaternion_orientation_tracker_top: orientation quaternion, radius, matrix out
// depends on qot_pkg and qot_div
//
// input channel: valid/stall with opcode, delta_x..delta_w, zoom_delta.
// opcode 0 rotates the stored quaternion by the delta and renormalizes;
// opcode 1 adds zoom_delta to the radius with saturation.
// every word in gives one word out: the 3x3 rotation matrix (Q2.14) and
// the camera offset -radius * third column (Q8.8).
// one multiplier is shared by all products, an isqrt runs one result bit a
// cycle and one restoring divider gives one quotient bit a cycle.
// a rotate runs 16 hamilton products, 4 squares, 29 square root steps,
// four divides and the matrix and offset steps. a rotate with zero norm
// skips the divides; a zoom runs only the matrix and offset steps. the
// next word is taken only after the result of the last has been taken.
// in_stall is high whenever a word is in work or its result waits.
// the result sits in registers until out_stall is low; the next word is
// not taken before then.
// reset sets the quaternion to (0,0,0,1) and the radius to 1.0.
module quaternion_orientation_tracker_top (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic opcode,
	input  logic signed [15:0] delta_x,
	input  logic signed [15:0] delta_y,
	input  logic signed [15:0] delta_z,
	input  logic signed [15:0] delta_w,
	input  logic signed [15:0] zoom_delta,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [15:0] m00,
	output logic signed [15:0] m01,
	output logic signed [15:0] m02,
	output logic signed [15:0] m10,
	output logic signed [15:0] m11,
	output logic signed [15:0] m12,
	output logic signed [15:0] m20,
	output logic signed [15:0] m21,
	output logic signed [15:0] m22,
	output logic signed [15:0] offset_x,
	output logic signed [15:0] offset_y,
	output logic signed [15:0] offset_z
);
	import qot_pkg::*;

	state_t state_q, state_d;
	logic signed [15:0] q_q [4];
	logic signed [15:0] d_q [4];
	logic signed [15:0] radius_q;
	logic signed [35:0] acc_q;
	logic signed [35:0] n_q [4];
	logic [27:0] m_q [4];
	logic [57:0] sum_q;
	logic [57:0] rad_q;
	logic [31:0] root_q;
	logic [31:0] rem_q;
	logic [4:0] step_q;
	logic [1:0] idx_q;
	logic [3:0] sub_q;
	logic signed [15:0] res_q [4];
	logic signed [15:0] mat_q [9];
	logic signed [15:0] ofs_q [3];
	logic busy_q;

	// shared multiplier
	logic signed [31:0] ma, mb;
	logic signed [63:0] prod;
	assign prod = ma * mb;

	logic div_start;
	logic div_busy;
	logic [39:0] dquo;
	logic [39:0] dnum;
	qot_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(dnum), .den(root_q), .busy(div_busy), .quo(dquo)
	);
	// magnitude never exceeds 2^24, so 26 bits carry it
	assign dnum = {m_q[idx_q][25:0], 14'd0} + {9'd0, root_q[31:1]};

	assign in_stall = busy_q;
	assign out_valid = (state_q == ST_OUT);

	// hamilton term table: sub 0..15 = 4 terms per component
	logic signed [15:0] ha, hb;
	logic hneg;
	always_comb begin
		ha = q_q[3]; hb = d_q[0]; hneg = 1'b0;
		case (sub_q)
			4'd0: begin ha = q_q[3]; hb = d_q[0]; end
			4'd1: begin ha = q_q[0]; hb = d_q[3]; end
			4'd2: begin ha = q_q[1]; hb = d_q[2]; end
			4'd3: begin ha = q_q[2]; hb = d_q[1]; hneg = 1'b1; end
			4'd4: begin ha = q_q[3]; hb = d_q[1]; end
			4'd5: begin ha = q_q[1]; hb = d_q[3]; end
			4'd6: begin ha = q_q[2]; hb = d_q[0]; end
			4'd7: begin ha = q_q[0]; hb = d_q[2]; hneg = 1'b1; end
			4'd8: begin ha = q_q[3]; hb = d_q[2]; end
			4'd9: begin ha = q_q[2]; hb = d_q[3]; end
			4'd10: begin ha = q_q[0]; hb = d_q[1]; end
			4'd11: begin ha = q_q[1]; hb = d_q[0]; hneg = 1'b1; end
			4'd12: begin ha = q_q[3]; hb = d_q[3]; end
			4'd13: begin ha = q_q[0]; hb = d_q[0]; hneg = 1'b1; end
			4'd14: begin ha = q_q[1]; hb = d_q[1]; hneg = 1'b1; end
			default: begin ha = q_q[2]; hb = d_q[2]; hneg = 1'b1; end
		endcase
	end

	// matrix term table: index (sub) picks pair products of the quaternion
	// products xx yy zz xy xz yz wx wy wz in sub 0..8
	logic signed [15:0] pa, pb;
	always_comb begin
		pa = q_q[0]; pb = q_q[0];
		case (sub_q)
			4'd0: begin pa = q_q[0]; pb = q_q[0]; end
			4'd1: begin pa = q_q[1]; pb = q_q[1]; end
			4'd2: begin pa = q_q[2]; pb = q_q[2]; end
			4'd3: begin pa = q_q[0]; pb = q_q[1]; end
			4'd4: begin pa = q_q[0]; pb = q_q[2]; end
			4'd5: begin pa = q_q[1]; pb = q_q[2]; end
			4'd6: begin pa = q_q[3]; pb = q_q[0]; end
			4'd7: begin pa = q_q[3]; pb = q_q[1]; end
			default: begin pa = q_q[3]; pb = q_q[2]; end
		endcase
	end

	logic signed [31:0] pp_q [9];

	// mux for multiplier
	always_comb begin
		ma = '0; mb = '0;
		unique case (state_q)
			ST_HAM: begin ma = 32'(ha); mb = 32'(hb); end
			ST_SQ: begin ma = {4'd0, m_q[idx_q]}; mb = {4'd0, m_q[idx_q]}; end
			ST_MAT: begin ma = 32'(pa); mb = 32'(pb); end
			ST_OFS: begin ma = 32'(radius_q); mb = 32'(mat_q[3 * idx_q + 2]); end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	// isqrt step, bit pair from top of rad_q
	logic [33:0] strial;
	logic [31:0] srem;
	assign srem = {rem_q[29:0], rad_q[57:56]};
	assign strial = {2'b0, srem} - {2'b0, root_q[29:0], 2'b01};

	function automatic logic signed [15:0] rnd_sat(input logic signed [35:0] v);
		logic signed [35:0] t;
		t = (v + 36'sd8192) >>> 14;
		return sat16(48'(t));
	endfunction

	always_comb begin
		state_d = state_q;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = (opcode == OP_ZOOM) ? ST_MAT : ST_HAM;
			ST_HAM: if (sub_q == 4'd15) state_d = ST_SQ;
			ST_SQ: if (idx_q == 2'd3) state_d = ST_SQRT;
			ST_SQRT: if (step_q == 5'd28) state_d = ST_DIVS;
			ST_DIVS: begin
				if (root_q == 32'd0) state_d = ST_MAT;
				else begin div_start = 1'b1; state_d = ST_DIVW; end
			end
			ST_DIVW: begin
				if (step_q == 5'd1 && !div_busy)
					state_d = (idx_q == 2'd3) ? ST_MAT : ST_DIVS;
			end
			ST_MAT: if (sub_q == 4'd9) state_d = ST_OFS;
			ST_OFS: if (idx_q == 2'd2) state_d = ST_OUT;
			ST_OUT: if (!out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q <= 1'b0;
			q_q[0] <= '0; q_q[1] <= '0; q_q[2] <= '0; q_q[3] <= ONE_Q14;
			radius_q <= ONE_Q8;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && in_valid) busy_q <= 1'b1;
			if (state_q == ST_OUT && !out_stall) busy_q <= 1'b0;
			if (state_q == ST_IDLE && in_valid && opcode == OP_ZOOM)
				radius_q <= sat16(48'(radius_q) + 48'(zoom_delta));
			if (state_q == ST_DIVW && !div_busy && step_q == 5'd1 && idx_q == 2'd3) begin
				q_q[0] <= res_q[0]; q_q[1] <= res_q[1]; q_q[2] <= res_q[2];
				q_q[3] <= sat16(n_q[3] < 0 ? -48'(dquo) : 48'(dquo));
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				d_q[0] <= delta_x; d_q[1] <= delta_y; d_q[2] <= delta_z; d_q[3] <= delta_w;
				sub_q <= '0; idx_q <= '0; acc_q <= '0; sum_q <= '0; step_q <= '0;
			end
			ST_HAM: begin
				if (sub_q[1:0] == 2'd3) begin
					n_q[sub_q[3:2]] <= hneg ? acc_q - 36'(prod) : acc_q + 36'(prod);
					acc_q <= '0;
				end else begin
					acc_q <= hneg ? acc_q - 36'(prod) : acc_q + 36'(prod);
				end
				sub_q <= sub_q + 4'd1;
				if (sub_q[1:0] == 2'd3) begin
					logic signed [35:0] nv;
					nv = hneg ? acc_q - 36'(prod) : acc_q + 36'(prod);
					m_q[sub_q[3:2]] <= 28'((nv < 0 ? -nv : nv) >> 8);
				end
			end
			ST_SQ: begin
				sum_q <= sum_q + 58'(unsigned'(prod));
				idx_q <= idx_q + 2'd1;
				if (idx_q == 2'd3) begin
					rad_q <= sum_q + 58'(unsigned'(prod));
					root_q <= '0; rem_q <= '0; step_q <= '0;
				end
			end
			ST_SQRT: begin
				if (!strial[33]) begin
					rem_q <= strial[31:0];
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					rem_q <= srem;
					root_q <= {root_q[30:0], 1'b0};
				end
				rad_q <= {rad_q[55:0], 2'b00};
				step_q <= step_q + 5'd1;
				idx_q <= '0;
			end
			ST_DIVS: begin
				step_q <= '0;
				sub_q <= '0;
			end
			ST_DIVW: begin
				if (step_q == 5'd0) step_q <= 5'd1;
				else if (!div_busy) begin
					res_q[idx_q] <= sat16(n_q[idx_q] < 0 ? -48'(dquo) : 48'(dquo));
					idx_q <= idx_q + 2'd1;
					step_q <= '0;
				end
			end
			ST_MAT: begin
				if (sub_q < 4'd9) pp_q[sub_q] <= prod[31:0];
				sub_q <= sub_q + 4'd1;
				idx_q <= '0;
				if (sub_q == 4'd9) begin
					mat_q[0] <= rnd_sat(36'sd268435456 - 2 * 36'(pp_q[1]) - 2 * 36'(pp_q[2]));
					mat_q[1] <= rnd_sat(2 * 36'(pp_q[3]) + 2 * 36'(pp_q[8]));
					mat_q[2] <= rnd_sat(2 * 36'(pp_q[4]) - 2 * 36'(pp_q[7]));
					mat_q[3] <= rnd_sat(2 * 36'(pp_q[3]) - 2 * 36'(pp_q[8]));
					mat_q[4] <= rnd_sat(36'sd268435456 - 2 * 36'(pp_q[0]) - 2 * 36'(pp_q[2]));
					mat_q[5] <= rnd_sat(2 * 36'(pp_q[5]) + 2 * 36'(pp_q[6]));
					mat_q[6] <= rnd_sat(2 * 36'(pp_q[4]) + 2 * 36'(pp_q[7]));
					mat_q[7] <= rnd_sat(2 * 36'(pp_q[5]) - 2 * 36'(pp_q[6]));
					mat_q[8] <= rnd_sat(36'sd268435456 - 2 * 36'(pp_q[0]) - 2 * 36'(pp_q[1]));
				end
			end
			ST_OFS: begin
				ofs_q[idx_q] <= rnd_sat(-signed'(prod[35:0]));
				idx_q <= idx_q + 2'd1;
			end
			default: ;
		endcase
	end

	assign m00 = mat_q[0]; assign m01 = mat_q[1]; assign m02 = mat_q[2];
	assign m10 = mat_q[3]; assign m11 = mat_q[4]; assign m12 = mat_q[5];
	assign m20 = mat_q[6]; assign m21 = mat_q[7]; assign m22 = mat_q[8];
	assign offset_x = ofs_q[0]; assign offset_y = ofs_q[1]; assign offset_z = ofs_q[2];

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid);
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !in_stall);
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall);
endmodule
